@@ rtl/csdt_pkg.sv @@
`timescale 1ns / 1ps

package csdt_pkg;

    // Field widths
    localparam int COORD_W   = 16;
    localparam int NORM_W    = 16;
    localparam int NORM_FRAC = 14;
    localparam int SQ_W      = 40;

    // Configuration port
    localparam int NUM_REGS = 7;
    localparam int PDATA_W  = 32;
    localparam int PADDR_W  = $clog2(NUM_REGS * 4);
    localparam int IDX_W    = PADDR_W - 2;

    // Datapath widths, each wide enough for every input pattern
    localparam int PMC_W      = COORD_W + 1;
    localparam int DOTP_W     = PMC_W + NORM_W;
    localparam int DOT_W      = DOTP_W + 2;
    localparam int D_W        = DOT_W - NORM_FRAC;
    localparam int DSQ_W      = 2 * D_W;
    localparam int DN_W       = D_W + NORM_W;
    localparam int RDN_W      = DN_W - NORM_FRAC;
    localparam int Q_W        = RDN_W + 1;
    localparam int QSQ_W      = 2 * Q_W;
    localparam int SQQ_W      = QSQ_W + 2;
    localparam int SQRT_STEPS = SQQ_W / 2;
    localparam int LEN_W      = SQRT_STEPS;
    localparam int DIFF_W     = LEN_W + 1;
    localparam int DIFFSQ_W   = 2 * DIFF_W;
    localparam int TOT_W      = DIFFSQ_W + 1;

    // Half an LSB of the Q1.14 normal, for round half up
    localparam logic signed [DOT_W-1:0] DOT_HALF = DOT_W'(1) <<< (NORM_FRAC - 1);
    localparam logic signed [DN_W-1:0]  DN_HALF  = DN_W'(1) <<< (NORM_FRAC - 1);

    localparam logic signed [NORM_W-1:0] NORMAL_Z_RESET = NORM_W'(16384);

    typedef enum logic [IDX_W-1:0] {
        REG_CENTER_X      = 0,
        REG_CENTER_Y      = 1,
        REG_CENTER_Z      = 2,
        REG_NORMAL_X      = 3,
        REG_NORMAL_Y      = 4,
        REG_NORMAL_Z      = 5,
        REG_CIRCLE_RADIUS = 6
    } csdt_reg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic signed [NORM_W-1:0]  normal_x;
        logic signed [NORM_W-1:0]  normal_y;
        logic signed [NORM_W-1:0]  normal_z;
        logic        [COORD_W-1:0] circle_radius;
    } csdt_cfg_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        logic        [SQ_W-1:0]    sphere_sq_radius;
    } csdt_query_t;

    typedef struct packed {
        logic [DSQ_W-1:0] d_sq;
        logic [SQ_W-1:0]  sphere;
        logic             degenerate;
    } csdt_side_t;

    typedef struct packed {
        logic [SQQ_W-1:0] sq_q;
        csdt_side_t       side;
    } csdt_front_t;

    typedef struct packed {
        logic [LEN_W-1:0] len;
        csdt_side_t       side;
    } csdt_root_t;

    typedef struct packed {
        logic [SQ_W-1:0] sq_dist;
        logic            hit;
        logic            degenerate;
    } csdt_result_t;

endpackage

@@ rtl/csdt_ifs.sv @@
`timescale 1ns / 1ps

interface csdt_query_if;
    logic                                valid;
    logic                                ready;
    logic signed [csdt_pkg::COORD_W-1:0] point_x;
    logic signed [csdt_pkg::COORD_W-1:0] point_y;
    logic signed [csdt_pkg::COORD_W-1:0] point_z;
    logic        [csdt_pkg::SQ_W-1:0]    sphere_sq_radius;

    modport source (output valid, point_x, point_y, point_z, sphere_sq_radius, input ready);
    modport sink (input valid, point_x, point_y, point_z, sphere_sq_radius, output ready);
endinterface

interface csdt_result_if;
    logic                          valid;
    logic                          ready;
    logic [csdt_pkg::SQ_W-1:0]     sq_dist;
    logic                          hit;
    logic                          degenerate;

    modport source (output valid, sq_dist, hit, degenerate, input ready);
    modport sink (input valid, sq_dist, hit, degenerate, output ready);
endinterface

@@ rtl/circle_sphere_distance_test.sv @@
`timescale 1ns / 1ps

// Circle-versus-sphere proximity test. A 3D circle (center, unit normal,
// radius) sits in APB registers; each query beat brings a point, which is
// also a sphere center, and that sphere's squared radius (Q16.16). The
// result beat carries the squared distance from the point to the circle
// (Q16.16, saturating at 2^40-1), hit when that distance does not exceed the
// sphere's squared radius, and degenerate when the point lies on the circle
// axis. The block takes one query per cycle while its output buffer is not
// full, and returns one result per query, in order. A query passes seven
// front stages for the offset, dot product and in-plane projection, one
// stage per root bit of the 25-step square root, then three back stages
// and the output register. A two-entry output buffer keeps queries flowing
// for one more beat while a result waits to be taken.
// Write registers only while no query is in flight.
module circle_sphere_distance_test
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [csdt_pkg::PADDR_W-1:0] paddr,
    input  logic [csdt_pkg::PDATA_W-1:0] pwdata,
    output logic [csdt_pkg::PDATA_W-1:0] prdata,
    output logic                         pready,
    csdt_query_if.sink                   query,
    csdt_result_if.source                result
);

    csdt_pkg::csdt_cfg_t    cfg;
    csdt_pkg::csdt_query_t  query_data;
    csdt_pkg::csdt_front_t  front_data;
    csdt_pkg::csdt_root_t   root_data;
    csdt_pkg::csdt_result_t result_data;
    logic                   adv;
    logic                   front_valid;
    logic                   root_valid;

    // Register file: circle geometry
    csdt_apb_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Pack the query beat; accept whenever the pipeline advances
    assign query_data.point_x          = query.point_x;
    assign query_data.point_y          = query.point_y;
    assign query_data.point_z          = query.point_z;
    assign query_data.sphere_sq_radius = query.sphere_sq_radius;
    assign query.ready                 = adv;

    // Offset, normal distance, in-plane vector and its squared length
    csdt_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .cfg       (cfg),
        .in_valid  (query.valid),
        .in_data   (query_data),
        .out_valid (front_valid),
        .out_data  (front_data)
    );

    // In-plane length
    csdt_sqrt u_sqrt
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .in_valid  (front_valid),
        .in_data   (front_data),
        .out_valid (root_valid),
        .out_data  (root_data)
    );

    // Distance, saturation, compare, and the output buffer that drives adv
    csdt_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .adv       (adv),
        .in_valid  (root_valid),
        .in_data   (root_data),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .out_data  (result_data)
    );

    assign result.sq_dist    = result_data.sq_dist;
    assign result.hit        = result_data.hit;
    assign result.degenerate = result_data.degenerate;

endmodule

@@ rtl/csdt_apb_regs.sv @@
`timescale 1ns / 1ps

module csdt_apb_regs
(
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [csdt_pkg::PADDR_W-1:0]    paddr,
    input  logic [csdt_pkg::PDATA_W-1:0]    pwdata,
    output logic [csdt_pkg::PDATA_W-1:0]    prdata,
    output logic                            pready,
    output csdt_pkg::csdt_cfg_t             cfg
);

    csdt_pkg::csdt_cfg_t cfg_reg;
    csdt_pkg::csdt_reg_t idx;
    logic                wr;

    assign idx    = csdt_pkg::csdt_reg_t'(paddr[csdt_pkg::PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '{center_x:      '0,
                         center_y:      '0,
                         center_z:      '0,
                         normal_x:      '0,
                         normal_y:      '0,
                         normal_z:      csdt_pkg::NORMAL_Z_RESET,
                         circle_radius: '0};
        end
        else if (wr)
        begin
            unique case (idx)
                csdt_pkg::REG_CENTER_X:      cfg_reg.center_x      <= pwdata[csdt_pkg::COORD_W-1:0];
                csdt_pkg::REG_CENTER_Y:      cfg_reg.center_y      <= pwdata[csdt_pkg::COORD_W-1:0];
                csdt_pkg::REG_CENTER_Z:      cfg_reg.center_z      <= pwdata[csdt_pkg::COORD_W-1:0];
                csdt_pkg::REG_NORMAL_X:      cfg_reg.normal_x      <= pwdata[csdt_pkg::NORM_W-1:0];
                csdt_pkg::REG_NORMAL_Y:      cfg_reg.normal_y      <= pwdata[csdt_pkg::NORM_W-1:0];
                csdt_pkg::REG_NORMAL_Z:      cfg_reg.normal_z      <= pwdata[csdt_pkg::NORM_W-1:0];
                csdt_pkg::REG_CIRCLE_RADIUS: cfg_reg.circle_radius <= pwdata[csdt_pkg::COORD_W-1:0];
                default:                     cfg_reg               <= cfg_reg;
            endcase
        end
    end

    // Zero-extend the register bits on read
    always_comb
    begin
        unique case (idx)
            csdt_pkg::REG_CENTER_X:      prdata = csdt_pkg::PDATA_W'(unsigned'(cfg_reg.center_x));
            csdt_pkg::REG_CENTER_Y:      prdata = csdt_pkg::PDATA_W'(unsigned'(cfg_reg.center_y));
            csdt_pkg::REG_CENTER_Z:      prdata = csdt_pkg::PDATA_W'(unsigned'(cfg_reg.center_z));
            csdt_pkg::REG_NORMAL_X:      prdata = csdt_pkg::PDATA_W'(unsigned'(cfg_reg.normal_x));
            csdt_pkg::REG_NORMAL_Y:      prdata = csdt_pkg::PDATA_W'(unsigned'(cfg_reg.normal_y));
            csdt_pkg::REG_NORMAL_Z:      prdata = csdt_pkg::PDATA_W'(unsigned'(cfg_reg.normal_z));
            csdt_pkg::REG_CIRCLE_RADIUS: prdata = csdt_pkg::PDATA_W'(cfg_reg.circle_radius);
            default:                     prdata = '0;
        endcase
    end

endmodule

@@ rtl/csdt_front.sv @@
`timescale 1ns / 1ps

// Seven stages: offset, dot terms, rounded dot, d*N and d^2,
// in-plane vector, its squares, squared length.
module csdt_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  csdt_pkg::csdt_cfg_t   cfg,
    input  logic                  in_valid,
    input  csdt_pkg::csdt_query_t in_data,
    output logic                  out_valid,
    output csdt_pkg::csdt_front_t out_data
);

    localparam int NSTG = 7;

    logic [NSTG:1] v_reg;

    logic signed [csdt_pkg::COORD_W-1:0] pt [3];
    logic signed [csdt_pkg::COORD_W-1:0] ctr [3];
    logic signed [csdt_pkg::NORM_W-1:0]  nrm [3];

    logic signed [csdt_pkg::PMC_W-1:0]  pmc1_reg [3];
    logic signed [csdt_pkg::PMC_W-1:0]  pmc2_reg [3];
    logic signed [csdt_pkg::PMC_W-1:0]  pmc3_reg [3];
    logic signed [csdt_pkg::PMC_W-1:0]  pmc4_reg [3];
    logic signed [csdt_pkg::DOTP_W-1:0] prod2_reg [3];
    logic signed [csdt_pkg::D_W-1:0]    d3_reg;
    logic signed [csdt_pkg::DN_W-1:0]   dn4_reg [3];
    logic        [csdt_pkg::DSQ_W-1:0]  dsq4_reg;
    logic        [csdt_pkg::DSQ_W-1:0]  dsq5_reg;
    logic        [csdt_pkg::DSQ_W-1:0]  dsq6_reg;
    logic signed [csdt_pkg::Q_W-1:0]    q5_reg [3];
    logic        [csdt_pkg::QSQ_W-1:0]  qsq6_reg [3];
    logic        [csdt_pkg::SQ_W-1:0]   sph_reg [NSTG-1:1];
    csdt_pkg::csdt_front_t              out_reg;

    logic signed [csdt_pkg::DOT_W-1:0] dot_sum;
    logic signed [csdt_pkg::DN_W-1:0]  dn_rnd [3];
    logic signed [csdt_pkg::RDN_W-1:0] rdn [3];
    logic        [csdt_pkg::SQQ_W-1:0] sq_sum;

    assign pt[0]  = in_data.point_x;
    assign pt[1]  = in_data.point_y;
    assign pt[2]  = in_data.point_z;
    assign ctr[0] = cfg.center_x;
    assign ctr[1] = cfg.center_y;
    assign ctr[2] = cfg.center_z;
    assign nrm[0] = cfg.normal_x;
    assign nrm[1] = cfg.normal_y;
    assign nrm[2] = cfg.normal_z;

    // Round half up: add half an LSB, keep the upper bits (floor)
    assign dot_sum = csdt_pkg::DOT_W'(prod2_reg[0]) + csdt_pkg::DOT_W'(prod2_reg[1])
                   + csdt_pkg::DOT_W'(prod2_reg[2]) + csdt_pkg::DOT_HALF;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            dn_rnd[i] = dn4_reg[i] + csdt_pkg::DN_HALF;
            rdn[i]    = dn_rnd[i][csdt_pkg::DN_W-1:csdt_pkg::NORM_FRAC];
        end
    end

    assign sq_sum = csdt_pkg::SQQ_W'(qsq6_reg[0]) + csdt_pkg::SQQ_W'(qsq6_reg[1])
                  + csdt_pkg::SQQ_W'(qsq6_reg[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[NSTG-1:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pmc1_reg[i]  <= pt[i] - ctr[i];
                prod2_reg[i] <= nrm[i] * pmc1_reg[i];
                pmc2_reg[i]  <= pmc1_reg[i];
                pmc3_reg[i]  <= pmc2_reg[i];
                dn4_reg[i]   <= d3_reg * nrm[i];
                pmc4_reg[i]  <= pmc3_reg[i];
                q5_reg[i]    <= pmc4_reg[i] - rdn[i];
                qsq6_reg[i]  <= q5_reg[i] * q5_reg[i];
            end
            sph_reg[1] <= in_data.sphere_sq_radius;
            for (int s = 2; s < NSTG; s++)
            begin
                sph_reg[s] <= sph_reg[s-1];
            end
            d3_reg   <= dot_sum[csdt_pkg::DOT_W-1:csdt_pkg::NORM_FRAC];
            dsq4_reg <= d3_reg * d3_reg;
            dsq5_reg <= dsq4_reg;
            dsq6_reg <= dsq5_reg;

            out_reg.sq_q            <= sq_sum;
            out_reg.side.d_sq       <= dsq6_reg;
            out_reg.side.sphere     <= sph_reg[NSTG-1];
            out_reg.side.degenerate <= (sq_sum == '0);
        end
    end

    assign out_valid = v_reg[NSTG];
    assign out_data  = out_reg;

endmodule

@@ rtl/csdt_sqrt.sv @@
`timescale 1ns / 1ps

// Bitwise floor square root, one result bit per stage.
module csdt_sqrt
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic                  in_valid,
    input  csdt_pkg::csdt_front_t in_data,
    output logic                  out_valid,
    output csdt_pkg::csdt_root_t  out_data
);

    localparam int N  = csdt_pkg::SQRT_STEPS;
    localparam int SW = csdt_pkg::SQQ_W;

    logic [SW-1:0]          rem_reg  [N];
    logic [SW-1:0]          root_reg [N];
    csdt_pkg::csdt_side_t   side_reg [N];
    logic [N-1:0]           v_reg;

    for (genvar k = 0; k < N; k++)
    begin : g_step
        localparam logic [SW:0] BIT = (SW + 1)'(1) << (SW - 2 - 2 * k);

        logic [SW-1:0]        rem_in;
        logic [SW-1:0]        root_in;
        csdt_pkg::csdt_side_t side_in;
        logic                 v_in;
        logic [SW:0]          trial;
        logic                 take;

        if (k == 0)
        begin : g_first
            assign rem_in  = in_data.sq_q;
            assign root_in = '0;
            assign side_in = in_data.side;
            assign v_in    = in_valid;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign side_in = side_reg[k-1];
            assign v_in    = v_reg[k-1];
        end

        assign trial = {1'b0, root_in} + BIT;
        assign take  = ({1'b0, rem_in} >= trial);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[k] <= 1'b0;
            end
            else if (adv)
            begin
                v_reg[k] <= v_in;
            end
        end

        // Subtract the trial value when it fits, shift the root either way
        always_ff @(posedge clk)
        begin
            if (adv)
            begin
                rem_reg[k]  <= take ? rem_in - trial[SW-1:0] : rem_in;
                root_reg[k] <= take ? (root_in >> 1) + BIT[SW-1:0] : (root_in >> 1);
                side_reg[k] <= side_in;
            end
        end
    end

    assign out_valid     = v_reg[N-1];
    assign out_data.len  = root_reg[N-1][csdt_pkg::LEN_W-1:0];
    assign out_data.side = side_reg[N-1];

endmodule

@@ rtl/csdt_back.sv @@
`timescale 1ns / 1ps

// Radial error, its square, the total, then a two-entry output buffer.
module csdt_back
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  csdt_pkg::csdt_cfg_t   cfg,
    output logic                  adv,
    input  logic                  in_valid,
    input  csdt_pkg::csdt_root_t  in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output csdt_pkg::csdt_result_t out_data
);

    logic [3:1] v_reg;

    logic signed [csdt_pkg::DIFF_W-1:0]  diff1_reg;
    logic        [csdt_pkg::DIFFSQ_W-1:0] diffsq2_reg;
    logic        [csdt_pkg::TOT_W-1:0]   tot3_reg;
    csdt_pkg::csdt_side_t                side_reg [3:1];

    csdt_pkg::csdt_result_t out_reg;
    csdt_pkg::csdt_result_t skid_reg;
    logic                   out_v_reg;
    logic                   skid_v_reg;

    csdt_pkg::csdt_result_t arr;
    logic                   arriving;
    logic                   pop;

    // Hold the whole pipeline only while the skid entry is occupied
    assign adv      = !skid_v_reg;
    assign arriving = adv && v_reg[3];
    assign pop      = out_v_reg && out_ready;

    always_comb
    begin
        arr.sq_dist    = (tot3_reg[csdt_pkg::TOT_W-1:csdt_pkg::SQ_W] != '0)
                       ? '1 : tot3_reg[csdt_pkg::SQ_W-1:0];
        arr.hit        = (arr.sq_dist <= side_reg[3].sphere);
        arr.degenerate = side_reg[3].degenerate;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (adv)
        begin
            v_reg <= {v_reg[2:1], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            diff1_reg   <= $signed(csdt_pkg::DIFF_W'(in_data.len))
                         - $signed(csdt_pkg::DIFF_W'(cfg.circle_radius));
            diffsq2_reg <= diff1_reg * diff1_reg;
            tot3_reg    <= csdt_pkg::TOT_W'(side_reg[2].d_sq) + csdt_pkg::TOT_W'(diffsq2_reg);
            side_reg[1] <= in_data.side;
            side_reg[2] <= side_reg[1];
            side_reg[3] <= side_reg[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!out_v_reg || pop)
        begin
            out_v_reg  <= skid_v_reg || arriving;
            skid_v_reg <= 1'b0;
        end
        else if (arriving)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_v_reg || pop)
        begin
            out_reg <= skid_v_reg ? skid_reg : arr;
        end
        else if (arriving)
        begin
            skid_reg <= arr;
        end
    end

    assign out_valid = out_v_reg;
    assign out_data  = out_reg;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import csdt_pkg::*;

    // Watchdog: cycles in a row with no beat on either channel and no register
    // access. The slowest correct beat is a long idle gap on the query side,
    // the pipeline, then a stalled result; this is many times that.
    localparam int STALL_LIMIT  = 4000;
    // Extra cycles after the last result, a bit more than the pipeline depth.
    localparam int DRAIN_CYCLES = 48;
    localparam int PHASES       = 8;
    localparam int PHASE_BEATS  = 250;
    localparam int IDLE_PCT     = 22;
    localparam int PRINT_CAP    = 40;

    localparam logic [SQ_W-1:0] SQ_TOP = '1;

    localparam csdt_cfg_t RESET_CIRCLE = '{16'sd0, 16'sd0, 16'sd0,
                                           16'sd0, 16'sd0, NORMAL_Z_RESET, 16'd0};
    // Every normal component at -2.0 (not unit), center at the far corner and
    // the largest radius: drives the squared distance into saturation.
    localparam csdt_cfg_t WILD_CIRCLE = '{16'sh8000, 16'sh8000, 16'sh8000,
                                          16'sh8000, 16'sh8000, 16'sh8000, 16'hFFFF};

    // One row of the directed table. stage 0 runs on the reset circle, stage 1
    // on WILD_CIRCLE. Rows with typed set carry their result; the rest are
    // checked against circle_distance.
    typedef struct packed {
        logic         stage;
        csdt_query_t  q;
        logic         typed;
        csdt_result_t want;
    } probe_t;

    localparam probe_t PROBES [16] = '{
        // point at the center: on the axis, distance zero, a hit against zero
        '{1'b0, '{16'sd0, 16'sd0, 16'sd0, 40'd0}, 1'b1, '{40'd0, 1'b1, 1'b1}},
        // one unit off in the plane, radius zero
        '{1'b0, '{16'sd256, 16'sd0, 16'sd0, 40'd0}, 1'b1, '{40'd65536, 1'b0, 1'b0}},
        // same point, sphere exactly on the distance
        '{1'b0, '{16'sd256, 16'sd0, 16'sd0, 40'd65536}, 1'b1, '{40'd65536, 1'b1, 1'b0}},
        // one unit up the axis, sphere just short
        '{1'b0, '{16'sd0, 16'sd0, 16'sd256, 40'd65535}, 1'b1, '{40'd65536, 1'b0, 1'b1}},
        // lowest z on the axis, widest sphere
        '{1'b0, '{16'sd0, 16'sd0, 16'sh8000, 40'hFF_FFFF_FFFF}, 1'b1,
          '{40'd1073741824, 1'b1, 1'b1}},
        // highest x in the plane
        '{1'b0, '{16'sd32767, 16'sd0, 16'sd0, 40'd0}, 1'b1, '{40'd1073676289, 1'b0, 1'b0}},
        // lowest y, highest z, sphere one below the distance
        '{1'b0, '{16'sd0, 16'sh8000, 16'sd32767, 40'd2147418112}, 1'b1,
          '{40'd2147418113, 1'b0, 1'b0}},
        // saturated distance: a hit only against the widest sphere
        '{1'b1, '{16'sd32767, 16'sd32767, 16'sd32767, 40'hFF_FFFF_FFFF}, 1'b1,
          '{40'hFF_FFFF_FFFF, 1'b1, 1'b0}},
        '{1'b1, '{16'sd32767, 16'sd32767, 16'sd32767, 40'hFF_FFFF_FFFE}, 1'b1,
          '{40'hFF_FFFF_FFFF, 1'b0, 1'b0}},
        // point at the center: distance is the radius squared
        '{1'b1, '{16'sh8000, 16'sh8000, 16'sh8000, 40'd4294836225}, 1'b1,
          '{40'd4294836225, 1'b1, 1'b1}},
        '{1'b1, '{16'sh8000, 16'sh8000, 16'sh8000, 40'd4294836224}, 1'b1,
          '{40'd4294836225, 1'b0, 1'b1}},
        '{1'b1, '{16'sd32767, 16'sh8000, 16'sd0, 40'd12345}, 1'b0, '0},
        '{1'b1, '{16'sd0, 16'sd0, 16'sd0, 40'd0}, 1'b0, '0},
        '{1'b1, '{-16'sd1, -16'sd1, -16'sd1, 40'h01_0000_0000}, 1'b0, '0},
        '{1'b1, '{16'sd1, -16'sd2, 16'sd3, 40'hAA_AAAA_AAAA}, 1'b0, '0},
        '{1'b1, '{16'sd16384, 16'sd16384, -16'sd16384, 40'h55_5555_5555}, 1'b0, '0}
    };

    logic                clk;
    logic                rst_n;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    csdt_query_if  query_ch ();
    csdt_result_if result_ch ();

    circle_sphere_distance_test uut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .query   (query_ch),
        .result  (result_ch)
    );

    csdt_cfg_t    circle;        // what the registers hold, as far as we know
    csdt_result_t due_dist [$];  // one entry per accepted query, oldest first
    csdt_result_t head;
    bit           steady;        // set: neither side idles
    int           mismatches;
    int           beats;
    int           quiet;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Squared distance from the query point to the circle, bit for bit.
    function automatic csdt_result_t circle_distance(csdt_cfg_t c, csdt_query_t q);
        longint            off [3];
        longint            nv [3];
        longint            qv [3];
        longint            along;
        longint            gap;
        longint unsigned   plane_sq;
        longint unsigned   root;
        longint unsigned   trial;
        longint unsigned   total;
        csdt_result_t      r;
        off[0] = longint'($signed(q.point_x)) - longint'($signed(c.center_x));
        off[1] = longint'($signed(q.point_y)) - longint'($signed(c.center_y));
        off[2] = longint'($signed(q.point_z)) - longint'($signed(c.center_z));
        nv[0]  = longint'($signed(c.normal_x));
        nv[1]  = longint'($signed(c.normal_y));
        nv[2]  = longint'($signed(c.normal_z));
        // signed height above the plane, rounded half up to Q8.8
        along = 0;
        for (int i = 0; i < 3; i++)
            along += nv[i] * off[i];
        along = (along + (64'sd1 <<< (NORM_FRAC - 1))) >>> NORM_FRAC;
        // in-plane part of the offset and its squared length
        plane_sq = 0;
        for (int i = 0; i < 3; i++)
        begin
            qv[i] = off[i] - ((along * nv[i] + (64'sd1 <<< (NORM_FRAC - 1))) >>> NORM_FRAC);
            plane_sq += longint'(qv[i] * qv[i]);
        end
        // floor square root, one root bit per pass from the top
        root = 0;
        for (int b = 31; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= plane_sq)
                root = trial;
        end
        gap   = longint'(root) - longint'(c.circle_radius);
        total = longint'(along * along) + longint'(gap * gap);
        if (total > 64'(SQ_TOP))
            total = 64'(SQ_TOP);
        r.sq_dist    = SQ_W'(total);
        r.hit        = (SQ_W'(total) <= q.sphere_sq_radius);
        r.degenerate = (plane_sq == 0);
        return r;
    endfunction

    function automatic logic signed [COORD_W-1:0] clamp_coord(int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return 16'sh8000;
        return COORD_W'(v);
    endfunction

    // A circle for one random phase; kinds cover axis normals, full noise,
    // both extremes, a zero normal and a diagonal unit normal.
    function automatic csdt_cfg_t make_circle(int kind);
        csdt_cfg_t c;
        int        n [3];
        int        spot;
        c.center_x      = COORD_W'(int'($urandom_range(16384)) - 8192);
        c.center_y      = COORD_W'(int'($urandom_range(16384)) - 8192);
        c.center_z      = COORD_W'(int'($urandom_range(16384)) - 8192);
        c.circle_radius = COORD_W'($urandom_range(4096));
        n    = '{0, 0, 0};
        spot = $urandom_range(2);
        case (kind)
            0: n[spot] = $urandom_range(1) ? 16384 : -16384;
            1:
            begin
                c.center_x      = COORD_W'($urandom);
                c.center_y      = COORD_W'($urandom);
                c.center_z      = COORD_W'($urandom);
                c.circle_radius = COORD_W'($urandom);
                for (int i = 0; i < 3; i++)
                    n[i] = int'($signed(NORM_W'($urandom)));
            end
            2:
            begin
                c.center_x      = 16'sd32767;
                c.center_y      = 16'sd32767;
                c.center_z      = 16'sd32767;
                c.circle_radius = 16'hFFFF;
                n = '{16384, 16384, 16384};
            end
            3:
            begin
                c.center_x      = 16'sh8000;
                c.center_y      = 16'sh8000;
                c.center_z      = 16'sh8000;
                c.circle_radius = 16'd0;
                n = '{-32768, -32768, -32768};
            end
            4: c.circle_radius = COORD_W'($urandom);
            default:
            begin
                for (int i = 0; i < 3; i++)
                    n[i] = $urandom_range(1) ? 11585 : -11585;
                n[spot] = 0;
            end
        endcase
        c.normal_x = NORM_W'(n[0]);
        c.normal_y = NORM_W'(n[1]);
        c.normal_z = NORM_W'(n[2]);
        return c;
    endfunction

    // Mostly points near the circle, some on its axis or at its center, the
    // rest anywhere. The sphere is often placed right at the distance so the
    // hit compare sees both sides of its boundary.
    function automatic csdt_query_t make_query(csdt_cfg_t c);
        csdt_query_t  q;
        csdt_result_t probe;
        logic [SQ_W-1:0] base;
        longint       s;
        int           pick;
        int           t;
        pick = $urandom_range(99);
        if (pick < 55)
        begin
            q.point_x = clamp_coord(int'(c.center_x) + int'($urandom_range(8192)) - 4096);
            q.point_y = clamp_coord(int'(c.center_y) + int'($urandom_range(8192)) - 4096);
            q.point_z = clamp_coord(int'(c.center_z) + int'($urandom_range(8192)) - 4096);
        end
        else if (pick < 65)
        begin
            t = int'($urandom_range(8192)) - 4096;
            q.point_x = clamp_coord(int'(c.center_x) + ((t * int'(c.normal_x)) >>> NORM_FRAC));
            q.point_y = clamp_coord(int'(c.center_y) + ((t * int'(c.normal_y)) >>> NORM_FRAC));
            q.point_z = clamp_coord(int'(c.center_z) + ((t * int'(c.normal_z)) >>> NORM_FRAC));
        end
        else if (pick < 70)
        begin
            q.point_x = c.center_x;
            q.point_y = c.center_y;
            q.point_z = c.center_z;
        end
        else
        begin
            q.point_x = COORD_W'($urandom);
            q.point_y = COORD_W'($urandom);
            q.point_z = COORD_W'($urandom);
        end
        q.sphere_sq_radius = '0;
        probe = circle_distance(c, q);
        base  = probe.sq_dist;
        pick  = $urandom_range(99);
        if (pick < 30)
        begin
            s = longint'(base) + (int'($urandom_range(4)) - 2);
            if (s < 0)
                s = 0;
            else if (s > longint'(SQ_TOP))
                s = longint'(SQ_TOP);
            q.sphere_sq_radius = SQ_W'(s);
        end
        else if (pick < 55)
            q.sphere_sq_radius = SQ_W'({$urandom, $urandom} % (64'(base) * 2 + 1));
        else if (pick < 85)
            q.sphere_sq_radius = SQ_W'({$urandom, $urandom});
        else if (pick < 90)
            q.sphere_sq_radius = '0;
        else if (pick < 95)
            q.sphere_sq_radius = SQ_TOP;
        else
            q.sphere_sq_radius = base;
        return q;
    endfunction

    task automatic note_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        mismatches++;
        // keep the log short when everything goes wrong at once
        if (mismatches <= PRINT_CAP)
            $display("mismatch at result %0d: %s got 0x%0h expected 0x%0h",
                     beats, what, got, want);
    endtask

    // One APB transfer: setup cycle, then access until pready. Sample pready
    // and prdata at the falling edge so nothing races the rising one; leave the
    // bus idle after so the next setup never lands in the same step.
    task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] addr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        bit done;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        done  = 1'b0;
        rdata = '0;
        while (!done)
        begin
            @(negedge clk);
            done  = pready;
            rdata = prdata;
            @(posedge clk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Write every register, read each one back, then poke the address just
    // past the last register, which must change nothing.
    task automatic program_circle(input csdt_cfg_t c);
        logic [15:0]        field [NUM_REGS];
        logic [PDATA_W-1:0] rd;
        field[REG_CENTER_X]      = c.center_x;
        field[REG_CENTER_Y]      = c.center_y;
        field[REG_CENTER_Z]      = c.center_z;
        field[REG_NORMAL_X]      = c.normal_x;
        field[REG_NORMAL_Y]      = c.normal_y;
        field[REG_NORMAL_Z]      = c.normal_z;
        field[REG_CIRCLE_RADIUS] = c.circle_radius;
        for (int i = 0; i < NUM_REGS; i++)
        begin
            apb_access(1'b1, PADDR_W'(i * 4), PDATA_W'(field[i]), rd);
            apb_access(1'b0, PADDR_W'(i * 4), '0, rd);
            if (rd[15:0] !== field[i])
                note_mismatch("register readback", rd[15:0], field[i]);
        end
        apb_access(1'b1, PADDR_W'(NUM_REGS * 4), '1, rd);
        circle = c;
    endtask

    // Offer one query beat, idling first at random. Check ready at the falling
    // edge; the rising edge after it is the one that takes the beat. Valid is
    // left high on return so back-to-back beats never toggle it.
    task automatic offer_query(input csdt_query_t q, input csdt_result_t want);
        bit taken;
        while (!steady && $urandom_range(99) < IDLE_PCT)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.valid            <= 1'b1;
        query_ch.point_x          <= q.point_x;
        query_ch.point_y          <= q.point_y;
        query_ch.point_z          <= q.point_z;
        query_ch.sphere_sq_radius <= q.sphere_sq_radius;
        taken = 1'b0;
        while (!taken)
        begin
            @(negedge clk);
            taken = query_ch.ready;
            @(posedge clk);
        end
        due_dist.push_back(want);
    endtask

    // Hold the sender until the pipeline has handed back every result.
    task automatic drain_results();
        while (due_dist.size() != 0)
            @(posedge clk);
    endtask

    // Result side: stall at random, never during the steady phase.
    always @(posedge clk)
        result_ch.ready <= steady || ($urandom_range(99) >= IDLE_PCT);

    // Compare each result beat with the oldest waiting expectation.
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (due_dist.size() == 0)
                note_mismatch("result with no query pending", result_ch.sq_dist, 0);
            else
            begin
                head = due_dist.pop_front();
                if (result_ch.sq_dist !== head.sq_dist)
                    note_mismatch("sq_dist", result_ch.sq_dist, head.sq_dist);
                if (result_ch.hit !== head.hit)
                    note_mismatch("hit", result_ch.hit, head.hit);
                if (result_ch.degenerate !== head.degenerate)
                    note_mismatch("degenerate", result_ch.degenerate, head.degenerate);
            end
            beats++;
        end
    end

    // Watchdog: any beat or register access restarts the count.
    always @(posedge clk)
    begin
        if (!rst_n || psel || (query_ch.valid && query_ch.ready)
            || (result_ch.valid && result_ch.ready))
            quiet <= 0;
        else if (quiet >= STALL_LIMIT)
        begin
            $display("circle_sphere_distance_test verification failed");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial
    begin
        csdt_query_t  q;
        csdt_result_t want;
        // drive every input to a known level before the first edge
        clk                       = 1'b0;
        rst_n                     = 1'b0;
        psel                      = 1'b0;
        penable                   = 1'b0;
        pwrite                    = 1'b0;
        paddr                     = '0;
        pwdata                    = '0;
        query_ch.valid            = 1'b0;
        query_ch.point_x          = '0;
        query_ch.point_y          = '0;
        query_ch.point_z          = '0;
        query_ch.sphere_sq_radius = '0;
        result_ch.ready           = 1'b0;
        steady                    = 1'b0;
        mismatches                = 0;
        beats                     = 0;
        quiet                     = 0;
        circle                    = RESET_CIRCLE;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table. The first rows run on the reset circle, so they also
        // prove the reset values; switch to the wild circle once the pipeline
        // is empty.
        for (int i = 0; i < $size(PROBES); i++)
        begin
            if (i > 0 && PROBES[i].stage != PROBES[i-1].stage)
            begin
                query_ch.valid <= 1'b0;
                drain_results();
                program_circle(WILD_CIRCLE);
            end
            want = PROBES[i].typed ? PROBES[i].want : circle_distance(circle, PROBES[i].q);
            offer_query(PROBES[i].q, want);
        end

        // Random phases, each on a fresh circle written while the block is
        // idle. Phase 3 runs with no idling on either side.
        for (int ph = 0; ph < PHASES; ph++)
        begin
            query_ch.valid <= 1'b0;
            drain_results();
            program_circle(make_circle(ph % 6));
            steady = (ph == 3);
            for (int n = 0; n < PHASE_BEATS; n++)
            begin
                q = make_query(circle);
                offer_query(q, circle_distance(circle, q));
            end
        end

        // Drop valid, let the last results out, then give stray beats a chance
        // to show up before the verdict.
        query_ch.valid <= 1'b0;
        steady = 1'b0;
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (due_dist.size() != 0)
            note_mismatch("results never returned", due_dist.size(), 0);

        if (mismatches == 0)
            $display("circle_sphere_distance_test verification clean");
        else
            $display("circle_sphere_distance_test verification failed");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/csdt_pkg.sv
rtl/csdt_ifs.sv
rtl/csdt_apb_regs.sv
rtl/csdt_front.sv
rtl/csdt_sqrt.sv
rtl/csdt_back.sv
rtl/circle_sphere_distance_test.sv
bench/testbench.sv
